/* rtl/hcd_pkg.sv */
// ----------------------------------------------------------------------------
// hcd_pkg
// Shared types, codes and helpers of the hashed cache directory core.
// ----------------------------------------------------------------------------
package hcd_pkg;

  // Default directory size and the fixed number of probes per key.
  localparam int DEF_DIR_LINES = 1024;
  localparam int NUM_PROBES    = 4;

  // Configuration register indexes and the reset value of the line count.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_LINES_IN_USE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BYTE_BUDGET  = 1'd1;
  localparam logic [10:0] LINES_IN_USE_RESET = 11'd1024;

  // Operation codes carried by an item.
  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_LOOKUP = 2'd2,
    KIND_EVICT  = 2'd3
  } kind_t;

  // One input item.
  typedef struct packed {
    kind_t        kind;
    logic [63:0]  key_first;
    logic [63:0]  key_second;
    logic [31:0]  entry_size;
    logic [39:0]  trim_bytes;
    logic [47:0]  now_ms;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic         hit;
    logic [9:0]   line_index;
    logic [31:0]  stored_size;
    logic [10:0]  evicted_count;
    logic [39:0]  total_bytes;
    logic [10:0]  used_lines;
  } out_item_t;

  // One directory line as stored in memory.
  typedef struct packed {
    logic [63:0]  key_first;
    logic [63:0]  key_second;
    logic [47:0]  time_ms;
    logic [31:0]  size;
  } line_t;

  // Datapath operations issued by the controller, one per cycle.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_WIPE,
    OP_LOAD,
    OP_DIV,
    OP_PRB_RD,
    OP_PRB_CAP,
    OP_SELECT,
    OP_CLR_TGT,
    OP_BUDGET,
    OP_SCAN_START,
    OP_SCAN,
    OP_EVICT,
    OP_WRITE,
    OP_RESULT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic  wipe_done;
    logic  div_done;
    logic  prb_last;
    logic  match;
    logic  over;
    logic  scan_done;
    logic  best_valid;
    kind_t kind;
  } dp_stat_t;

  // Subtract a line size from the total, saturating at zero.
  function automatic logic [39:0] sat_sub(input logic [39:0] a, input logic [31:0] b);
    return (a >= 40'(b)) ? (a - 40'(b)) : '0;
  endfunction

endpackage

/* rtl/hcd_ram.sv */
// ----------------------------------------------------------------------------
// hcd_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module hcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/hcd_ctrl.sv */
// ----------------------------------------------------------------------------
// hcd_ctrl
// Sequencer: clears the directory after reset, then steps the datapath
// through probe indexing, probe reads, replacement and eviction per item.
// ----------------------------------------------------------------------------
module hcd_ctrl import hcd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_WIPE, S_IDLE, S_DIV, S_PRB_RD, S_PRB_CAP, S_SELECT, S_CLR,
    S_BUDGET, S_CHECK, S_SCAN, S_EVICT, S_WRITE, S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;

  // Next state and the operation for this cycle.
  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    case (state_r)
      S_WIPE: begin
        cmd.op = OP_WIPE;
        if (stat.wipe_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.op = OP_DIV;
        if (stat.div_done) begin
          state_nxt = (stat.kind == KIND_EVICT) ? S_BUDGET : S_PRB_RD;
        end
      end
      S_PRB_RD: begin
        cmd.op    = OP_PRB_RD;
        state_nxt = S_PRB_CAP;
      end
      S_PRB_CAP: begin
        cmd.op    = OP_PRB_CAP;
        state_nxt = stat.prb_last ? S_SELECT : S_PRB_RD;
      end
      S_SELECT: begin
        cmd.op = OP_SELECT;
        case (stat.kind)
          KIND_ADD:    state_nxt = S_CLR;
          KIND_REMOVE: state_nxt = stat.match ? S_CLR : S_DONE;
          KIND_LOOKUP: state_nxt = stat.match ? S_WRITE : S_DONE;
          default:     state_nxt = S_DONE;
        endcase
      end
      S_CLR: begin
        cmd.op    = OP_CLR_TGT;
        state_nxt = (stat.kind == KIND_ADD) ? S_BUDGET : S_DONE;
      end
      S_BUDGET: begin
        cmd.op    = OP_BUDGET;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (stat.over) begin
          cmd.op    = OP_SCAN_START;
          state_nxt = S_SCAN;
        end else begin
          state_nxt = (stat.kind == KIND_ADD) ? S_WRITE : S_DONE;
        end
      end
      S_SCAN: begin
        cmd.op = OP_SCAN;
        if (stat.scan_done) state_nxt = S_EVICT;
      end
      S_EVICT: begin
        // No occupied line left ends the trim early.
        if (stat.best_valid) begin
          cmd.op    = OP_EVICT;
          state_nxt = S_CHECK;
        end else begin
          state_nxt = (stat.kind == KIND_ADD) ? S_WRITE : S_DONE;
        end
      end
      S_WRITE: begin
        cmd.op    = OP_WRITE;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        cmd.op    = OP_RESULT;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and busy flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_WIPE;
      busy_r  <= 1'b1;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

  assign busy = busy_r;

endmodule

/* rtl/hcd_dp.sv */
// ----------------------------------------------------------------------------
// hcd_dp
// Datapath: configuration registers, probe index dividers, probe capture,
// replacement choice, oldest-line scan, totals and the line memory.
// ----------------------------------------------------------------------------
module hcd_dp import hcd_pkg::*; #(
  parameter int DIR_LINES = DEF_DIR_LINES
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [39:0]          cfg_wdata,
  input  in_item_t             in_item,
  input  dp_cmd_t              cmd,
  output dp_stat_t             stat,
  output logic                 out_strobe,
  output out_item_t            out_item
);

  localparam int LW = $clog2(DIR_LINES);
  localparam int NW = $clog2(DIR_LINES + 1);
  localparam int LINE_W = $bits(line_t);

  // Configuration and running state.
  logic [10:0]   liu_r;
  logic [39:0]   budget_r;
  logic [39:0]   total_r, total_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;
  logic [LW:0]   sa_r;
  logic          best_v_r;
  logic          out_strobe_r;

  // Item registers.
  kind_t         kind_r;
  logic [63:0]   k1_r, k2_r;
  logic [31:0]   size_r;
  logic [39:0]   allowed_r;
  logic [47:0]   now_r;
  logic [NW-1:0] n_r;
  logic [4:0]    div_cnt_r;
  logic [31:0]   chunk_r [NUM_PROBES];
  logic [LW-1:0] rem_r   [NUM_PROBES];
  logic [LW-1:0] rem_step [NUM_PROBES];
  logic [1:0]    pcnt_r;
  logic [47:0]   ptime_r [NUM_PROBES];
  logic [31:0]   psize_r [NUM_PROBES];
  logic [NUM_PROBES-1:0] pmatch_r;

  // Chosen line and eviction bookkeeping.
  logic [LW-1:0] tgt_r;
  logic          tocc_r;
  logic [31:0]   tsz_r;
  logic          hit_r;
  logic [31:0]   stored_r;
  logic          trig_r;
  logic [39:0]   target_r;
  logic [NW-1:0] ev_r;
  logic [LW-1:0] sp_r;
  logic [LW-1:0] best_idx_r;
  logic [47:0]   best_time_r;
  logic [31:0]   best_size_r;
  out_item_t     out_r;

  // Memory ports.
  logic          ram_we;
  logic [LW-1:0] ram_waddr, ram_raddr;
  line_t         ram_wline, rd;
  logic [LINE_W-1:0] ram_rdata;

  // Combinational helpers.
  logic          any_m;
  logic [1:0]    mp;
  logic [LW-1:0] vt;
  logic [47:0]   vtime;
  logic [31:0]   vsz;
  logic          vfound;
  logic [40:0]   add_sum;
  logic [41:0]   budget3;
  logic [39:0]   goal;
  logic [LW:0]   rem_tmp [NUM_PROBES];

  hcd_ram #(.WIDTH(LINE_W), .DEPTH(DIR_LINES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wline),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd = line_t'(ram_rdata);

  // One restoring remainder step per probe lane.
  always_comb begin
    for (int p = 0; p < NUM_PROBES; p++) begin
      rem_tmp[p]  = {rem_r[p], chunk_r[p][31]};
      rem_step[p] = (rem_tmp[p] >= (LW+1)'(n_r)) ? LW'(rem_tmp[p] - (LW+1)'(n_r))
                                                 : LW'(rem_tmp[p]);
    end
  end

  // First matching probe, and the replacement victim without a match.
  always_comb begin
    any_m  = 1'b0;
    mp     = 2'd0;
    for (int p = NUM_PROBES - 1; p >= 0; p--) begin
      if (pmatch_r[p]) begin
        any_m = 1'b1;
        mp    = 2'(p);
      end
    end
    vt     = rem_r[0];
    vtime  = ptime_r[0];
    vsz    = psize_r[0];
    vfound = 1'b0;
    for (int p = 0; p < NUM_PROBES; p++) begin
      if (!vfound) begin
        if (ptime_r[p] == '0) begin
          vt     = rem_r[p];
          vtime  = '0;
          vsz    = psize_r[p];
          vfound = 1'b1;
        end else if (ptime_r[p] < vtime) begin
          vt    = rem_r[p];
          vtime = ptime_r[p];
          vsz   = psize_r[p];
        end
      end
    end
  end

  // Budget trigger sum and the three-quarter goal.
  assign add_sum = {1'b0, total_r} + 41'(size_r);
  assign budget3 = {2'b00, budget_r} + {1'b0, budget_r, 1'b0};
  assign goal    = sat_sub(budget3[41:2], size_r);

  // Memory address and write selection.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = tgt_r;
    ram_wline = '0;
    ram_raddr = (cmd.op == OP_PRB_RD) ? rem_r[pcnt_r] : sa_r[LW-1:0];
    case (cmd.op)
      OP_WIPE: begin
        ram_we    = 1'b1;
        ram_waddr = sa_r[LW-1:0];
      end
      OP_CLR_TGT: ram_we = 1'b1;
      OP_EVICT: begin
        ram_we    = 1'b1;
        ram_waddr = best_idx_r;
      end
      OP_WRITE: begin
        ram_we               = 1'b1;
        ram_wline.key_first  = k1_r;
        ram_wline.key_second = k2_r;
        ram_wline.time_ms    = now_r;
        ram_wline.size       = (kind_r == KIND_ADD) ? size_r : tsz_r;
      end
      default: ram_we = 1'b0;
    endcase
  end

  // Total and occupied count updates.
  always_comb begin
    total_nxt = total_r;
    cnt_nxt   = cnt_r;
    case (cmd.op)
      OP_CLR_TGT: begin
        if (tocc_r) begin
          total_nxt = sat_sub(total_r, tsz_r);
          cnt_nxt   = (cnt_r != '0) ? cnt_r - 1'b1 : cnt_r;
        end
      end
      OP_EVICT: begin
        total_nxt = sat_sub(total_r, best_size_r);
        cnt_nxt   = (cnt_r != '0) ? cnt_r - 1'b1 : cnt_r;
      end
      OP_WRITE: begin
        if (kind_r == KIND_ADD) begin
          total_nxt = add_sum[40] ? '1 : add_sum[39:0];
          cnt_nxt   = cnt_r + 1'b1;
        end
      end
      default: total_nxt = total_r;
    endcase
  end

  // Control state with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      liu_r        <= LINES_IN_USE_RESET;
      budget_r     <= '0;
      total_r      <= '0;
      cnt_r        <= '0;
      sa_r         <= '0;
      best_v_r     <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_LINES_IN_USE: liu_r    <= cfg_wdata[10:0];
          REG_BYTE_BUDGET:  budget_r <= cfg_wdata;
          default:          liu_r    <= liu_r;
        endcase
      end
      total_r      <= total_nxt;
      cnt_r        <= cnt_nxt;
      out_strobe_r <= (cmd.op == OP_RESULT);
      case (cmd.op)
        OP_WIPE:       sa_r <= sa_r + 1'b1;
        OP_SCAN_START: begin
          sa_r     <= '0;
          best_v_r <= 1'b0;
        end
        OP_SCAN: begin
          sa_r <= sa_r + 1'b1;
          if (sa_r != '0 && rd.time_ms != '0 &&
              (!best_v_r || rd.time_ms < best_time_r)) begin
            best_v_r <= 1'b1;
          end
        end
        default: sa_r <= sa_r;
      endcase
    end
  end

  // Item payload registers.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        kind_r    <= in_item.kind;
        k1_r      <= in_item.key_first;
        k2_r      <= in_item.key_second;
        size_r    <= in_item.entry_size;
        allowed_r <= in_item.trim_bytes;
        now_r     <= (in_item.now_ms == '0) ? 48'd1 : in_item.now_ms;
        if (liu_r == '0) begin
          n_r <= NW'(1);
        end else if (32'(liu_r) > DIR_LINES) begin
          n_r <= NW'(DIR_LINES);
        end else begin
          n_r <= NW'(liu_r);
        end
        chunk_r[0] <= in_item.key_first[31:0];
        chunk_r[1] <= in_item.key_first[63:32];
        chunk_r[2] <= in_item.key_second[31:0];
        chunk_r[3] <= in_item.key_second[63:32];
        for (int p = 0; p < NUM_PROBES; p++) rem_r[p] <= '0;
        div_cnt_r <= '0;
        pcnt_r    <= '0;
        tgt_r     <= '0;
        tocc_r    <= 1'b0;
        tsz_r     <= '0;
        hit_r     <= 1'b0;
        stored_r  <= '0;
        trig_r    <= 1'b0;
        ev_r      <= '0;
      end
      OP_DIV: begin
        for (int p = 0; p < NUM_PROBES; p++) begin
          rem_r[p]   <= rem_step[p];
          chunk_r[p] <= {chunk_r[p][30:0], 1'b0};
        end
        div_cnt_r <= div_cnt_r + 1'b1;
      end
      OP_PRB_CAP: begin
        ptime_r[pcnt_r]  <= rd.time_ms;
        psize_r[pcnt_r]  <= rd.size;
        pmatch_r[pcnt_r] <= (rd.time_ms != '0) && (rd.key_first == k1_r) &&
                            (rd.key_second == k2_r);
        pcnt_r           <= pcnt_r + 1'b1;
      end
      OP_SELECT: begin
        hit_r    <= any_m;
        stored_r <= (kind_r == KIND_LOOKUP && any_m) ? psize_r[mp] : '0;
        if (any_m) begin
          tgt_r  <= rem_r[mp];
          tocc_r <= 1'b1;
          tsz_r  <= psize_r[mp];
        end else if (kind_r == KIND_ADD) begin
          tgt_r  <= vt;
          tocc_r <= (vtime != '0);
          tsz_r  <= vsz;
        end
      end
      OP_BUDGET: begin
        if (kind_r == KIND_EVICT) begin
          trig_r   <= 1'b1;
          target_r <= allowed_r;
        end else begin
          trig_r   <= (budget_r != '0) && (add_sum >= {1'b0, budget_r});
          target_r <= goal;
        end
      end
      OP_SCAN: begin
        sp_r <= sa_r[LW-1:0];
        if (sa_r != '0 && rd.time_ms != '0 &&
            (!best_v_r || rd.time_ms < best_time_r)) begin
          best_idx_r  <= sp_r;
          best_time_r <= rd.time_ms;
          best_size_r <= rd.size;
        end
      end
      OP_EVICT: ev_r <= ev_r + 1'b1;
      OP_RESULT: begin
        out_r.hit           <= hit_r;
        out_r.line_index    <= 10'(tgt_r);
        out_r.stored_size   <= stored_r;
        out_r.evicted_count <= 11'(ev_r);
        out_r.total_bytes   <= total_r;
        out_r.used_lines    <= 11'(cnt_r);
      end
      default: kind_r <= kind_r;
    endcase
  end

  // Status toward the controller.
  always_comb begin
    stat.wipe_done  = (sa_r == (LW+1)'(DIR_LINES - 1));
    stat.div_done   = (div_cnt_r == 5'd31);
    stat.prb_last   = (pcnt_r == 2'(NUM_PROBES - 1));
    stat.match      = any_m;
    stat.over       = trig_r && (total_r > target_r);
    stat.scan_done  = (sa_r == (LW+1)'(DIR_LINES));
    stat.best_valid = best_v_r;
    stat.kind       = kind_r;
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_r;

endmodule

/* rtl/hashed_cache_directory_lru.sv */
// ----------------------------------------------------------------------------
// hashed_cache_directory_lru_core
// Four-probe skewed directory with oldest-first replacement and byte budget.
// ----------------------------------------------------------------------------
// After reset the block clears the line memory with busy high. An item
// is taken when start is high and busy is low, and its result appears on
// out_item with out_strobe high for exactly one cycle; the receiver cannot
// hold it off. The strobe cycle is the first idle cycle, so the next item
// can already be taken in it. The four probe indices come from a
// bit-serial remainder unit, then each of the four probes is read from the
// line memory and then captured. Evict items skip the probe reads. Every
// line evicted by the budget or by the evict kind adds one full scan of
// the memory.
module hashed_cache_directory_lru_core import hcd_pkg::*; #(
  parameter int DIR_LINES = DEF_DIR_LINES
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  in_item_t             in_item,
  output logic                 out_strobe,
  output out_item_t            out_item,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [39:0]          cfg_wdata
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  hcd_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  hcd_dp #(.DIR_LINES(DIR_LINES)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_item    (in_item),
    .cmd        (cmd),
    .stat       (stat),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

  // An accepted item keeps the block busy until its result.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("busy not raised after accept");

  // A result comes out only once the block has gone idle.
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy) else $error("result while busy");

  // One result per item: strobes never come back to back.
  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe) else $error("repeated result strobe");

  // The occupied count never exceeds the directory size.
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (32'(out_item.used_lines) <= DIR_LINES))
    else $error("occupied count out of range");

endmodule

/* dv/tb_hashed_cache_directory_lru_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hashed_cache_directory_lru_core
// Self-checking bench for the hashed cache directory core. Directed and
// random add, remove, lookup and evict items are applied in bursts under
// several line counts and byte budgets. A scoreboard keeps its own copy of
// the directory, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
module tb_hashed_cache_directory_lru_core;
  import hcd_pkg::*;

  localparam int  LINES     = DEF_DIR_LINES;
  localparam int  LIMIT     = 10000000;
  localparam int  SCAN_WAIT = 200;

  // Directory model and the queue of expected results.
  class dir_scoreboard;
    logic [63:0] kf[LINES];
    logic [63:0] ks[LINES];
    logic [47:0] tm[LINES];
    logic [31:0] sz[LINES];
    logic [39:0] total;
    logic [10:0] used;
    logic [10:0] line_count;
    logic [39:0] budget;
    out_item_t   pending[$];
    int          errors;
    int          checked;

    function void clear_all();
      for (int i = 0; i < LINES; i++) begin
        kf[i] = '0; ks[i] = '0; tm[i] = '0; sz[i] = '0;
      end
      total = '0;
      used = '0;
      line_count = LINES_IN_USE_RESET;
      budget = '0;
      pending.delete();
      errors = 0;
      checked = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [39:0] val);
      if (idx == REG_LINES_IN_USE) line_count = val[10:0];
      else budget = val;
    endfunction

    function void drop_line(int i);
      if (tm[i] != 0) begin
        total = (total >= 40'(sz[i])) ? total - 40'(sz[i]) : '0;
        if (used > 0) used--;
      end
      kf[i] = '0; ks[i] = '0; tm[i] = '0; sz[i] = '0;
    endfunction

    // Oldest-first trimming over every line of the memory.
    function int trim_to(logic [39:0] goal);
      int n, best;
      n = 0;
      while (total > goal) begin
        best = -1;
        for (int i = 0; i < LINES; i++)
          if (tm[i] != 0 && (best < 0 || tm[i] < tm[best])) best = i;
        if (best < 0) break;
        drop_line(best);
        n++;
      end
      return n;
    endfunction

    function void note_item(in_item_t it);
      out_item_t   r;
      int          pr[NUM_PROBES];
      logic [31:0] ch[NUM_PROBES];
      int          div, found, tgt;
      logic [47:0] now;
      logic [40:0] sum;
      logic [41:0] goal;
      r = '0;
      now = (it.now_ms == 0) ? 48'd1 : it.now_ms;
      div = (line_count == 0) ? 1 : (line_count > LINES ? LINES : int'(line_count));
      ch[0] = it.key_first[31:0];  ch[1] = it.key_first[63:32];
      ch[2] = it.key_second[31:0]; ch[3] = it.key_second[63:32];
      found = -1;
      for (int p = 0; p < NUM_PROBES; p++) begin
        pr[p] = int'(64'(ch[p]) % 64'(div));
        if (found < 0 && tm[pr[p]] != 0 && kf[pr[p]] == it.key_first &&
            ks[pr[p]] == it.key_second) found = pr[p];
      end
      case (it.kind)
        KIND_ADD: begin
          if (found >= 0) begin
            r.hit = 1'b1;
            tgt = found;
          end else begin
            tgt = pr[0];
            for (int p = 0; p < NUM_PROBES; p++) begin
              if (tm[pr[p]] == 0) begin
                tgt = pr[p];
                break;
              end
              if (tm[pr[p]] < tm[tgt]) tgt = pr[p];
            end
          end
          drop_line(tgt);
          sum = 41'(total) + 41'(it.entry_size);
          if (budget != 0 && sum >= 41'(budget)) begin
            goal = (42'(budget) * 3) >> 2;
            goal = (goal >= 42'(it.entry_size)) ? goal - 42'(it.entry_size) : '0;
            r.evicted_count = 11'(trim_to(goal[39:0]));
          end
          tm[tgt] = now; kf[tgt] = it.key_first; ks[tgt] = it.key_second;
          sz[tgt] = it.entry_size;
          sum = 41'(total) + 41'(it.entry_size);
          total = sum[40] ? '1 : sum[39:0];
          used++;
          r.line_index = 10'(tgt);
        end
        KIND_REMOVE: if (found >= 0) begin
          r.hit = 1'b1;
          r.line_index = 10'(found);
          drop_line(found);
        end
        KIND_LOOKUP: if (found >= 0) begin
          r.hit = 1'b1;
          r.line_index = 10'(found);
          r.stored_size = sz[found];
          tm[found] = now;
        end
        default: r.evicted_count = 11'(trim_to(it.trim_bytes));
      endcase
      r.total_bytes = total;
      r.used_lines = used;
      pending.push_back(r);
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      if (pending.size() == 0) begin
        $error("result with nothing expected: %p", got);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (got.hit !== e.hit) begin
        $error("hit: expected %0d, got %0d", e.hit, got.hit); errors++;
      end
      if (got.line_index !== e.line_index) begin
        $error("line_index: expected %0d, got %0d", e.line_index, got.line_index); errors++;
      end
      if (got.stored_size !== e.stored_size) begin
        $error("stored_size: expected %0d, got %0d", e.stored_size, got.stored_size);
        errors++;
      end
      if (got.evicted_count !== e.evicted_count) begin
        $error("evicted_count: expected %0d, got %0d", e.evicted_count, got.evicted_count);
        errors++;
      end
      if (got.total_bytes !== e.total_bytes) begin
        $error("total_bytes: expected %0d, got %0d", e.total_bytes, got.total_bytes);
        errors++;
      end
      if (got.used_lines !== e.used_lines) begin
        $error("used_lines: expected %0d, got %0d", e.used_lines, got.used_lines);
        errors++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  in_item_t             in_item;
  logic                 out_strobe;
  out_item_t            out_item;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [39:0]          cfg_wdata;

  dir_scoreboard board;
  int            cycles;
  int            items_sent;
  int            burst_left;
  logic [47:0]   clock_ms;
  logic [63:0]   known_kf[$];
  logic [63:0]   known_ks[$];

  hashed_cache_directory_lru_core DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_strobe(out_strobe), .out_item(out_item), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b0; #10;
    clk = 1'b1; #10;
  end

  // Results are taken at the edge that ends the strobe cycle.
  always @(posedge clk) begin
    if (rst_n && out_strobe) board.check_result(out_item);
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_hashed_cache_directory_lru_core: done, errors");
      $finish;
    end
  end

  // Offer one item and hold it until the block takes it.
  task automatic send_item(in_item_t it);
    start   <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_item(it);
    items_sent++;
    // Bursts of back-to-back items separated by random gaps.
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk);
      burst_left = $urandom_range(0, 12);
    end
  endtask

  // Wait until every expected result has come.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (SCAN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [39:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.set_reg(idx, val);
    @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Random item, mostly reusing keys that were added before.
  function automatic in_item_t make_item(int max_size, logic [39:0] max_allowed);
    in_item_t it;
    int       k, pick;
    it = '0;
    pick = $urandom_range(0, 99);
    if (pick < 45) it.kind = KIND_ADD;
    else if (pick < 62) it.kind = KIND_REMOVE;
    else if (pick < 92) it.kind = KIND_LOOKUP;
    else it.kind = KIND_EVICT;
    if (known_kf.size() != 0 && $urandom_range(0, 3) != 0) begin
      k = $urandom_range(0, known_kf.size() - 1);
      it.key_first = known_kf[k];
      it.key_second = known_ks[k];
    end else begin
      it.key_first = rand64();
      it.key_second = rand64();
      if (it.kind == KIND_ADD) begin
        known_kf.push_back(it.key_first);
        known_ks.push_back(it.key_second);
        if (known_kf.size() > 64) begin
          void'(known_kf.pop_front());
          void'(known_ks.pop_front());
        end
      end
    end
    it.entry_size = ($urandom_range(0, 19) == 0) ? $urandom() :
                    32'($urandom_range(0, max_size));
    it.trim_bytes = ($urandom_range(0, 9) == 0) ? 40'({$urandom(), $urandom()}) :
                    40'({$urandom(), $urandom()} % (64'(max_allowed) + 1));
    clock_ms = clock_ms + 48'($urandom_range(0, 3));
    it.now_ms = ($urandom_range(0, 49) == 0) ? 48'({$urandom(), $urandom()}) : clock_ms;
    return it;
  endfunction

  function automatic in_item_t pack_item(kind_t kd, logic [63:0] a, logic [63:0] b,
                                         logic [31:0] s, logic [39:0] al,
                                         logic [47:0] t);
    in_item_t it;
    it.kind = kd; it.key_first = a; it.key_second = b;
    it.entry_size = s; it.trim_bytes = al; it.now_ms = t;
    return it;
  endfunction

  // Random phase under one register setting.
  task automatic random_phase(logic [10:0] lines, logic [39:0] budget, int count,
                              int max_size, logic [39:0] max_allowed);
    drain();
    write_reg(REG_LINES_IN_USE, lines);
    write_reg(REG_BYTE_BUDGET, budget);
    known_kf.delete();
    known_ks.delete();
    repeat (count) send_item(make_item(max_size, max_allowed));
  endtask

  initial begin
    board = new();
    board.clear_all();
    rst_n = 1'b0; start = 1'b0; in_item = '0;
    cfg_we = 1'b0; cfg_index = '0; cfg_wdata = '0;
    cycles = 0; items_sent = 0; burst_left = 0; clock_ms = 48'd100;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty lookups, all-zero key, extremes, ties and saturation.
    send_item(pack_item(KIND_LOOKUP, '0, '0, '0, '0, '0));
    send_item(pack_item(KIND_REMOVE, '0, '0, '0, '0, 48'd5));
    send_item(pack_item(KIND_ADD, '0, '0, '1, '1, '0));
    send_item(pack_item(KIND_LOOKUP, '0, '0, '0, '0, '1));
    send_item(pack_item(KIND_ADD, '1, '1, '1, '1, '1));
    send_item(pack_item(KIND_ADD, 64'h5, 64'h7, 32'd9, '0, 48'd3));
    send_item(pack_item(KIND_ADD, 64'h5, 64'h7, 32'd4, '0, 48'd4));
    send_item(pack_item(KIND_LOOKUP, 64'h5, 64'h7, '0, '0, 48'd6));
    send_item(pack_item(KIND_REMOVE, 64'h5, 64'h7, '0, '0, 48'd7));
    send_item(pack_item(KIND_EVICT, '0, '0, '0, 40'd100, 48'd8));
    send_item(pack_item(KIND_EVICT, '0, '0, '0, '0, 48'd9));
    drain();

    // Tiny directory: lines_in_use of 0 acts as one line, ties on time.
    write_reg(REG_LINES_IN_USE, 11'd0);
    send_item(pack_item(KIND_ADD, 64'h11, 64'h22, 32'd10, '0, 48'd20));
    send_item(pack_item(KIND_ADD, 64'h33, 64'h44, 32'd10, '0, 48'd20));
    drain();
    write_reg(REG_LINES_IN_USE, 11'h7FF);
    write_reg(REG_BYTE_BUDGET, 40'd100);
    send_item(pack_item(KIND_ADD, 64'h1_0000_0002, 64'h3, 32'd60, '0, 48'd30));
    send_item(pack_item(KIND_ADD, 64'h9, 64'h8, 32'd50, '0, 48'd31));
    send_item(pack_item(KIND_ADD, 64'hA, 64'hB, 32'd200, '0, 48'd32));
    send_item(pack_item(KIND_EVICT, '0, '0, '0, 40'd0, 48'd33));
    drain();
    write_reg(REG_BYTE_BUDGET, 40'hFF_FFFF_FFFF);
    send_item(pack_item(KIND_ADD, 64'hC, 64'hD, '1, '0, 48'd40));
    send_item(pack_item(KIND_EVICT, '0, '0, '0, '1, 48'd41));

    // Random phases across line counts and budgets, extremes included.
    random_phase(11'd4, 40'd0, 250, 1000, 40'd3000);
    random_phase(11'd1, 40'd500, 150, 200, 40'd600);
    random_phase(11'd64, 40'd2000, 400, 300, 40'd3000);
    random_phase(11'd1024, 40'd0, 250, 5000, 40'd40000);
    random_phase(11'd1500, 40'hFF_FFFF_FFFF, 200, 100000, 40'd200000);
    random_phase(11'd13, 40'd1, 150, 50, 40'd100);
    random_phase(11'd200, 40'd5000, 350, 400, 40'd6000);

    drain();
    $display("covered %0d items and %0d checked results over seven register settings",
             items_sent, board.checked);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("tb_hashed_cache_directory_lru_core: done, clean");
    end else begin
      $display("tb_hashed_cache_directory_lru_core: done, errors");
    end
    $finish;
  end
endmodule

/* filelist.f */
rtl/hcd_pkg.sv
rtl/hcd_ram.sv
rtl/hcd_ctrl.sv
rtl/hcd_dp.sv
rtl/hashed_cache_directory_lru.sv
dv/tb_hashed_cache_directory_lru_core.sv
